// ----- rtl/sha512hc_pkg.sv -----
// shared types, constants and round table of the sha-512 hash core
`default_nettype none

package sha512hc_pkg;

    localparam int WORD_W  = 64;
    localparam int HASH_N  = 8;
    localparam int BLOCK_N = 16;
    localparam int ROUNDS  = 80;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int RND_W   = 7;
    localparam int POS_W   = 4;
    localparam int BEAT_W  = 72;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HASH_N-1:0][WORD_W-1:0] t_hash;

    // word source for a push into the block buffer
    localparam logic [2:0] SRC_DATA   = 3'd0;
    localparam logic [2:0] SRC_PADDED = 3'd1;
    localparam logic [2:0] SRC_MARK   = 3'd2;
    localparam logic [2:0] SRC_ZERO   = 3'd3;
    localparam logic [2:0] SRC_LEN    = 3'd4;

    localparam logic [POS_W-1:0] POS_LEN_HI = 4'd14;
    localparam logic [POS_W-1:0] POS_FULL   = 4'd15;

    typedef struct packed {
        logic             push;
        logic [2:0]       src;
        logic             len_word;
        logic             len_last;
        logic             start;
        logic             round;
        logic [RND_W-1:0] rnd;
        logic             fin;
        logic             digest;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
    } t_stat;

    localparam t_hash HASH_IV = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    localparam t_word ROUND_K [0:ROUNDS-1] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

`default_nettype wire

// ----- rtl/sha512hc_ctrl.sv -----
// sequencer: input intake, padding pushes, round count and digest hand-off
`default_nettype none

module sha512hc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_last,
    input  wire                   i_in_full,
    output logic                  o_in_ready,
    input  wire sha512hc_pkg::t_stat i_stat,
    input  wire                   i_ob_busy,
    output sha512hc_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MARK   = 3'd1;
    localparam logic [2:0] S_PADZ   = 3'd2;
    localparam logic [2:0] S_PADLEN = 3'd3;
    localparam logic [2:0] S_COMP   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_DIGEST = 3'd6;

    localparam logic [sha512hc_pkg::RND_W-1:0] RND_LAST =
        sha512hc_pkg::RND_W'(sha512hc_pkg::ROUNDS - 1);

    logic [2:0]                      r_state, n_state;
    logic [2:0]                      r_after, n_after;
    logic [sha512hc_pkg::RND_W-1:0]  r_round, n_round;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_after    = r_after;
        n_round    = r_round;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push = 1'b1;
                    if (!i_in_last) begin
                        o_cmd.src      = sha512hc_pkg::SRC_DATA;
                        o_cmd.len_word = 1'b1;
                    end else if (i_in_full) begin
                        o_cmd.src      = sha512hc_pkg::SRC_DATA;
                        o_cmd.len_last = 1'b1;
                        n_state        = S_MARK;
                    end else begin
                        o_cmd.src      = sha512hc_pkg::SRC_PADDED;
                        o_cmd.len_last = 1'b1;
                        n_state        = S_PADZ;
                    end
                end
            end
            S_MARK: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = sha512hc_pkg::SRC_MARK;
                n_state    = S_PADZ;
            end
            S_PADZ: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = sha512hc_pkg::SRC_ZERO;
                if (i_stat.pos == sha512hc_pkg::POS_LEN_HI) begin
                    n_state = S_PADLEN;
                end
            end
            S_PADLEN: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = sha512hc_pkg::SRC_LEN;
                n_state    = S_DIGEST;
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                o_cmd.rnd   = r_round;
                if (r_round == RND_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = r_after;
            end
            S_DIGEST: begin
                // wait until the previous digest has drained
                if (!i_ob_busy) begin
                    o_cmd.digest = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a push into the last slot fills the block: run the rounds, then resume
        if (o_cmd.push && i_stat.pos == sha512hc_pkg::POS_FULL) begin
            o_cmd.start = 1'b1;
            n_after     = n_state;
            n_state     = S_COMP;
            n_round     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_round <= n_round;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sha512hc_dp.sv -----
// datapath: block buffer as schedule window, round unit, chaining hash, bit length
`default_nettype none

module sha512hc_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire sha512hc_pkg::t_cmd            i_cmd,
    input  wire [sha512hc_pkg::WORD_W-1:0]     i_data,
    input  wire [sha512hc_pkg::CNT_W-1:0]      i_nbytes,
    output sha512hc_pkg::t_stat                o_stat,
    output sha512hc_pkg::t_hash                o_hash
);

    function automatic sha512hc_pkg::t_word ror(input sha512hc_pkg::t_word x,
                                                input int unsigned n);
        return (x >> n) | (x << (32'd64 - n));
    endfunction

    function automatic sha512hc_pkg::t_word bsig0(input sha512hc_pkg::t_word x);
        return ror(x, 28) ^ ror(x, 34) ^ ror(x, 39);
    endfunction

    function automatic sha512hc_pkg::t_word bsig1(input sha512hc_pkg::t_word x);
        return ror(x, 14) ^ ror(x, 18) ^ ror(x, 41);
    endfunction

    function automatic sha512hc_pkg::t_word ssig0(input sha512hc_pkg::t_word x);
        return ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
    endfunction

    function automatic sha512hc_pkg::t_word ssig1(input sha512hc_pkg::t_word x);
        return ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
    endfunction

    sha512hc_pkg::t_word               r_w [0:sha512hc_pkg::BLOCK_N-1];
    sha512hc_pkg::t_hash               r_hash;
    sha512hc_pkg::t_hash               r_work;
    logic [sha512hc_pkg::POS_W-1:0]    r_pos;
    sha512hc_pkg::t_word               r_len;

    logic [sha512hc_pkg::CNT_W-1:0]    w_nb;
    logic [5:0]                        w_bits;
    sha512hc_pkg::t_word               w_keep;
    sha512hc_pkg::t_word               w_padded;
    sha512hc_pkg::t_word               w_push;
    sha512hc_pkg::t_word               w_sched;
    sha512hc_pkg::t_word               w_shift_in;
    sha512hc_pkg::t_word               w_t1;
    sha512hc_pkg::t_word               w_t2;
    sha512hc_pkg::t_word               w_ch;
    sha512hc_pkg::t_word               w_maj;

    // counts above eight act as eight
    assign w_nb     = i_nbytes[3] ? 4'd8 : i_nbytes;
    assign w_bits   = {w_nb[2:0], 3'b000};
    assign w_keep   = ~({sha512hc_pkg::WORD_W{1'b1}} >> w_bits);
    assign w_padded = (i_data & w_keep) | (64'h80 << (6'd56 - w_bits));

    always_comb begin
        case (i_cmd.src)
            sha512hc_pkg::SRC_DATA:   w_push = i_data;
            sha512hc_pkg::SRC_PADDED: w_push = w_padded;
            sha512hc_pkg::SRC_MARK:   w_push = 64'h8000_0000_0000_0000;
            sha512hc_pkg::SRC_LEN:    w_push = r_len;
            default:                  w_push = '0;
        endcase
    end

    // next schedule word w[t+16] from the window taps
    assign w_sched = r_w[0] + ssig0(r_w[1]) + r_w[9] + ssig1(r_w[14]);
    assign w_shift_in = i_cmd.push ? w_push : w_sched;

    assign w_ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign w_maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^
                   (r_work[1] & r_work[2]);
    assign w_t1  = r_work[7] + bsig1(r_work[4]) + w_ch +
                   sha512hc_pkg::ROUND_K[i_cmd.rnd] + r_w[0];
    assign w_t2  = bsig0(r_work[0]) + w_maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round) begin
            for (int i = 0; i < sha512hc_pkg::BLOCK_N - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha512hc_pkg::BLOCK_N-1] <= w_shift_in;
        end
        if (i_cmd.start) begin
            r_work <= r_hash;
        end else if (i_cmd.round) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + w_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= sha512hc_pkg::HASH_IV;
            r_pos  <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.fin) begin
                for (int i = 0; i < sha512hc_pkg::HASH_N; i++) begin
                    r_hash[i] <= r_hash[i] + r_work[i];
                end
            end else if (i_cmd.digest) begin
                r_hash <= sha512hc_pkg::HASH_IV;
            end
            if (i_cmd.digest) begin
                r_len <= '0;
            end else if (i_cmd.len_word) begin
                r_len <= r_len + 64'd64;
            end else if (i_cmd.len_last) begin
                r_len <= r_len + {57'd0, w_nb, 3'b000};
            end
        end
    end

    assign o_stat.pos = r_pos;
    assign o_hash     = r_hash;

endmodule

`default_nettype wire

// ----- rtl/sha512hc_obuf.sv -----
// digest output buffer: holds eight words and sends them one beat each
`default_nettype none

module sha512hc_obuf (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_load,
    input  wire sha512hc_pkg::t_hash           i_hash,
    input  wire                                i_ready,
    output logic                               o_valid,
    output logic [sha512hc_pkg::WORD_W-1:0]    o_word,
    output logic [sha512hc_pkg::IDX_W-1:0]     o_index,
    output logic                               o_last
);

    sha512hc_pkg::t_hash               r_buf;
    logic [sha512hc_pkg::IDX_W-1:0]    r_idx;
    logic                              r_busy;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_hash;
        end else if (r_busy && i_ready) begin
            for (int i = 0; i < sha512hc_pkg::HASH_N - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_idx  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 1'b1;
            if (o_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_valid = r_busy;
    assign o_word  = r_buf[0];
    assign o_index = r_idx;
    assign o_last  = (r_idx == sha512hc_pkg::IDX_W'(sha512hc_pkg::HASH_N - 1));

endmodule

`default_nettype wire

// ----- rtl/sha512_hash_core_unit.sv -----
// SHA-512 hash core (FIPS 180-4): streaming message words in, eight digest
// words out. Message words are taken one beat per cycle while tready is high
// into a 16-word block buffer; the beat that fills a block holds off input
// while the single round unit runs the 80 rounds (one per cycle) and the
// chaining add follows. A tlast beat with fewer than eight valid bytes is
// padded in place, a full one gets the marker in a word of its own; pad
// pushes and one or two block compressions follow, then the digest moves to
// its own buffer and leaves as eight beats, index 0 first, tlast on index 7.
// That buffer drains while the next message is already being taken. Only a tlast
// beat may carry fewer than eight valid bytes; an empty tlast beat is allowed.
`default_nettype none

module sha512_hash_core_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
    input  wire [sha512hc_pkg::BEAT_W-1:0]     i_s_axis_tdata,
    input  wire                                i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [63:0] digest_word, [66:64] digest_index, [71:67] zero
    output logic [sha512hc_pkg::BEAT_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    sha512hc_pkg::t_cmd                 w_cmd;
    sha512hc_pkg::t_stat                w_stat;
    sha512hc_pkg::t_hash                w_hash;
    logic [sha512hc_pkg::WORD_W-1:0]    w_word;
    logic [sha512hc_pkg::IDX_W-1:0]     w_index;

    sha512hc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_in_full  (i_s_axis_tdata[67]),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .i_ob_busy  (o_m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    sha512hc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_data   (i_s_axis_tdata[63:0]),
        .i_nbytes (i_s_axis_tdata[67:64]),
        .o_stat   (w_stat),
        .o_hash   (w_hash)
    );

    sha512hc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_cmd.digest),
        .i_hash  (w_hash),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_word  (w_word),
        .o_index (w_index),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'd0, w_index, w_word};

endmodule

`default_nettype wire

// ----- rtl/sha512hc_checker.sv -----
// port-level checks of the hash core's digest stream, bound to the top level
`default_nettype none

module sha512hc_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    input  wire [sha512hc_pkg::BEAT_W-1:0]     o_m_axis_tdata,
    input  wire                                o_m_axis_tlast
);

    logic w_out_beat;
    assign w_out_beat = o_m_axis_tvalid && i_m_axis_tready;

    // a stalled digest beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("digest beat changed while stalled");

    // tlast marks exactly the eighth word
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[66:64] == 3'd7)))
        else $error("tlast does not match digest index");

    // a digest starts at index 0
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_m_axis_tdata[66:64] == 3'd0)
        else $error("digest did not start at index 0");

    // words of one digest follow back to back in index order
    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tdata[66:64] == $past(o_m_axis_tdata[66:64]) + 3'd1)
        else $error("digest words out of order");

    // nothing leaves right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("digest beat right after reset");

endmodule

bind sha512_hash_core_unit sha512hc_checker u_sha512hc_checker (.*);

`default_nettype wire

// ----- verif/sha512hc_digest_checker.sv -----
// digest checker for the sha-512 core: tracks message beats, predicts and compares digest beats
`timescale 1ns / 100ps

module sha512hc_digest_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    input  wire                             i_s_tready,
    // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
    input  wire [sha512hc_pkg::BEAT_W-1:0]  i_s_tdata,
    input  wire                             i_s_tlast,
    input  wire                             i_m_tvalid,
    input  wire                             i_m_tready,
    // [63:0] digest_word, [66:64] digest_index, [71:67] zero
    input  wire [sha512hc_pkg::BEAT_W-1:0]  i_m_tdata,
    input  wire                             i_m_tlast,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_beats_seen
);

    import sha512hc_pkg::*;

    localparam int MAX_REPORTS = 10;

    localparam logic [63:0] INIT_H [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_C [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    typedef struct packed {
        logic [63:0]      word;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_digest_beat;

    t_digest_beat digest_q[$];

    logic [63:0]      chain_h [0:7];
    logic [63:0]      msg_block [0:15];
    logic [POS_W-1:0] fill_pos;
    logic [63:0]      bit_count;
    int               fails;
    int               beats;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // 80 rounds over the buffered block, schedule expanded in place
    task automatic compress_block();
        logic [63:0] v [0:7];
        logic [63:0] w, w15, w2, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w = msg_block[t];
            end else begin
                w15 = msg_block[(t - 15) & 15];
                w2  = msg_block[(t - 2) & 15];
                w = msg_block[t & 15]
                    + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7))
                    + msg_block[(t - 7) & 15]
                    + (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6));
                msg_block[t & 15] = w;
            end
            t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_C[t] + w;
            t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endtask

    task automatic absorb_word(input logic [63:0] w);
        msg_block[fill_pos] = w;
        fill_pos = fill_pos + 1'b1;
        if (fill_pos == '0) compress_block();
    endtask

    task automatic take_message_beat(input logic [63:0] data, input logic [3:0] nb_raw,
                                     input logic lst);
        logic [3:0]   nb;
        logic [63:0]  keep;
        t_digest_beat exp_beat;
        if (!lst) begin
            bit_count = bit_count + 64'd64;
            absorb_word(data);
        end else begin
            nb = (nb_raw > 4'd8) ? 4'd8 : nb_raw;
            bit_count = bit_count + 64'(nb) * 64'd8;
            if (nb == 4'd8) begin
                absorb_word(data);
                absorb_word(64'h8000_0000_0000_0000);
            end else begin
                // bytes past the count are dropped, the marker byte follows the last one
                keep = ~(64'hffff_ffff_ffff_ffff >> (8 * nb));
                absorb_word((data & keep) | (64'h80 << (56 - 8 * nb)));
            end
            while (fill_pos != POS_LEN_HI) absorb_word('0);
            absorb_word('0);
            absorb_word(bit_count);
            for (int i = 0; i < 8; i++) begin
                exp_beat.word  = chain_h[i];
                exp_beat.index = IDX_W'(i);
                exp_beat.last  = (i == 7);
                digest_q.push_back(exp_beat);
                chain_h[i] = INIT_H[i];
            end
            bit_count = '0;
            fill_pos  = '0;
        end
    endtask

    task automatic check_digest_beat(input logic [63:0] word, input logic [IDX_W-1:0] index,
                                     input logic lst);
        t_digest_beat exp_beat;
        if (digest_q.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: digest beat with nothing pending: word %h index %0d last %b",
                         $realtime, word, index, lst);
        end else begin
            exp_beat = digest_q.pop_front();
            if (word !== exp_beat.word || index !== exp_beat.index || lst !== exp_beat.last)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("%0t: digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                             $realtime, exp_beat.word, exp_beat.index, exp_beat.last,
                             word, index, lst);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) chain_h[i] = INIT_H[i];
            for (int i = 0; i < 16; i++) msg_block[i] = '0;
            fill_pos  = '0;
            bit_count = '0;
            fails     = 0;
            beats     = 0;
            digest_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                take_message_beat(i_s_tdata[63:0], i_s_tdata[67:64], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                beats++;
                check_digest_beat(i_m_tdata[63:0], i_m_tdata[64 +: IDX_W], i_m_tlast);
            end
        end
        o_fail_count <= fails;
        o_pending    <= digest_q.size();
        o_beats_seen <= beats;
    end

endmodule

// ----- verif/tb.sv -----
// testbench top for the sha-512 core: clock, reset, message stimulus, output stalls and verdict
`timescale 1ns / 100ps

module tb;

    import sha512hc_pkg::*;

    localparam int WORD_TARGET  = 450;
    localparam int HOLD_CYCLES  = 3000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_TICKS = 200;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_THIRD} t_rx_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BEAT_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [BEAT_W-1:0] m_tdata;
    logic              m_tlast;
    int                fail_count;
    int                pending;
    int                beats_seen;
    int                words_sent;
    int                burst_left;

    sha512_hash_core_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    sha512hc_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats_seen (beats_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // one message beat; bursts of random length separated by random gaps
    task automatic put_word(input logic [63:0] w, input logic [3:0] nb, input logic lst);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = 60;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, nb, w};
        s_tlast  <= lst;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_message(input int nwords, input logic [3:0] last_nb);
        for (int i = 0; i < nwords; i++)
            put_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        put_word(rand_word(), last_nb, 1'b1);
    endtask

    task automatic drain_digests();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // receiver: one long hold-off once the first random digests flow, else shifting patterns
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        m_tready  = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && beats_seen >= 56) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    initial begin
        int idle_ticks;
        idle_ticks = 0;
        wait (i_rst_n === 1'b1);
        while (idle_ticks < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_ticks = 0;
            else idle_ticks++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int         nwords;
        logic [3:0] last_nb;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        words_sent = 0;
        burst_left = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, junk in the data word
        put_word(64'hdead_beef_0123_4567, 4'd0, 1'b1);
        // three bytes with junk in the unused low bytes
        put_word(64'h6162_63ff_ffff_ffff, 4'd3, 1'b1);
        // full last word, marker goes into a word of its own
        put_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
        // byte count above eight on the last word
        put_word(64'h0000_0000_0000_0000, 4'd15, 1'b1);
        // seven bytes, marker fills the last byte
        put_word(64'hffff_ffff_ffff_ffff, 4'd7, 1'b1);
        // marker lands in the next-to-last slot: no room for the length
        put_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0);
        put_word(64'h0000_0000_0000_0000, 4'd15, 1'b0);
        put_word(64'haaaa_aaaa_aaaa_aaaa, 4'd3, 1'b0);
        put_word(64'h5555_5555_5555_5555, 4'd8, 1'b0);
        for (int i = 0; i < 9; i++)
            put_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        put_word(rand_word(), 4'd8, 1'b1);

        drain_digests();

        while (words_sent < WORD_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: nwords = $urandom_range(0, 6);
                6, 7, 8:          nwords = $urandom_range(7, 20);
                default:          nwords = $urandom_range(21, 40);
            endcase
            last_nb = ($urandom_range(0, 3) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) drain_digests();
            send_message(nwords, last_nb);
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
